// ----- rtl/csre_pkg.sv -----
// ============================================================================
// csre_pkg
// Shared types and codes of the counting-sort rank engine.
// ============================================================================
package csre_pkg;

    localparam int ACTION_W = 3;
    localparam int LABEL_W  = 6;
    localparam int EIDX_W   = 12;
    localparam int PIDX_W   = 7;
    localparam int PARTS_W  = 7;
    localparam int VALUE_W  = 13;
    localparam int STATUS_W = 3;

    typedef logic [VALUE_W-1:0] t_value;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 3'd0,
        ACT_LOAD   = 3'd1,
        ACT_FINISH = 3'd2,
        ACT_POS    = 3'd3,
        ACT_START  = 3'd4
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK           = 3'd0,
        STS_BAD_LABEL    = 3'd1,
        STS_FULL         = 3'd2,
        STS_BAD_INDEX    = 3'd3,
        STS_NOT_FINISHED = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,   // zeroing sweep over the bucket memory
        S_RUN   = 2'd1,   // taking beats, one-deep pipe behind the memories
        S_WALK  = 2'd2,   // prefix-sum walk over all buckets
        S_POS   = 2'd3    // second read of a sorted-position lookup
    } t_state;

endpackage

// ----- rtl/csre_ram.sv -----
// ============================================================================
// csre_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module csre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/csre_ctrl.sv -----
// ============================================================================
// csre_ctrl
// Sequencer of the rank engine: beat pipeline, read-modify-write of bucket
// words with forwarding, clearing sweep, prefix-sum walk, result register.
// ============================================================================
module csre_ctrl
    import csre_pkg::*;
#(
    parameter int MAX_ITEMS = 4096,
    parameter int MAX_PARTS = 64,
    localparam int IDX_W  = $clog2(MAX_ITEMS),
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1),
    localparam int PART_W = $clog2(MAX_PARTS),
    localparam int BKT_W  = 2 * CNT_W,
    localparam int ELEM_W = PART_W + IDX_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [PARTS_W-1:0]  i_parts,
    // request channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [LABEL_W-1:0]  i_label,
    input  logic [EIDX_W-1:0]   i_element_index,
    input  logic [PIDX_W-1:0]   i_part_index,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [VALUE_W-1:0]  o_value,
    output logic [STATUS_W-1:0] o_status,
    // bucket memory: {count, start}
    output logic                o_bkt_we,
    output logic [PART_W-1:0]   o_bkt_waddr,
    output logic [BKT_W-1:0]    o_bkt_wdata,
    output logic [PART_W-1:0]   o_bkt_raddr,
    input  logic [BKT_W-1:0]    i_bkt_rdata,
    // element memory: {label, rank}
    output logic                o_elem_we,
    output logic [IDX_W-1:0]    o_elem_waddr,
    output logic [ELEM_W-1:0]   o_elem_wdata,
    output logic [IDX_W-1:0]    o_elem_raddr,
    input  logic [ELEM_W-1:0]   i_elem_rdata
);

    localparam logic [PART_W:0] WALK_END  = (PART_W + 1)'(MAX_PARTS);
    localparam logic [PART_W:0] SWEEP_END = (PART_W + 1)'(MAX_PARTS - 1);
    localparam logic [PART_W-1:0] LAST_PART = PART_W'(MAX_PARTS - 1);

    t_state              r_state, n_state;
    logic                r_s1_valid, n_s1_valid;
    t_action             r_act;
    logic [LABEL_W-1:0]  r_label;
    logic [EIDX_W-1:0]   r_eidx;
    logic [PIDX_W-1:0]   r_pidx;
    logic [CNT_W-1:0]    r_ec, n_ec;
    logic                r_finished, n_finished;
    logic                r_fwd, n_fwd;
    logic [BKT_W-1:0]    r_fwd_data;
    logic [PART_W:0]     r_walk_idx, n_walk_idx;
    logic                r_walk_dv, n_walk_dv;
    logic [PART_W-1:0]   r_walk_wa, n_walk_wa;
    logic [CNT_W-1:0]    r_run, n_run;
    logic [PART_W-1:0]   r_pos_addr, n_pos_addr;
    logic [IDX_W-1:0]    r_pos_rank, n_pos_rank;
    logic                r_out_valid, n_out_valid;
    t_value              r_out_value, n_out_value;
    t_status             r_out_status, n_out_status;

    logic [PARTS_W-1:0]  live_parts;
    logic                out_free;
    logic                accept;
    logic                in_rdy;
    logic [BKT_W-1:0]    cur_bkt;
    logic [CNT_W-1:0]    cur_cnt;
    logic [CNT_W-1:0]    cur_start;
    logic [CNT_W-1:0]    rd_cnt;
    logic [CNT_W-1:0]    rd_start;
    logic [PART_W-1:0]   elem_lbl;
    logic [IDX_W-1:0]    elem_rank;
    logic                lbl_bad;
    logic                store_full;
    logic                eidx_bad;
    logic                pidx_bad;
    logic                pidx_top;
    logic                pos_ok;
    logic                s1_emit;
    logic                s1_stay;
    t_value              s1_value;
    t_status             s1_status;
    logic                walk_last;

    assign live_parts = (32'(i_parts) < 32'(MAX_PARTS)) ? i_parts : PARTS_W'(MAX_PARTS);

    // a load right behind a load to the same bucket sees the word being written
    assign cur_bkt   = r_fwd ? r_fwd_data : i_bkt_rdata;
    assign cur_cnt   = cur_bkt[BKT_W-1 -: CNT_W];
    assign cur_start = cur_bkt[CNT_W-1:0];
    assign rd_cnt    = i_bkt_rdata[BKT_W-1 -: CNT_W];
    assign rd_start  = i_bkt_rdata[CNT_W-1:0];
    assign elem_lbl  = i_elem_rdata[ELEM_W-1 -: PART_W];
    assign elem_rank = i_elem_rdata[IDX_W-1:0];

    assign lbl_bad    = {1'b0, r_label} >= live_parts;
    assign store_full = r_ec == CNT_W'(MAX_ITEMS);
    assign eidx_bad   = 32'(r_eidx) >= 32'(r_ec);
    assign pidx_bad   = r_pidx > live_parts;
    assign pidx_top   = 32'(r_pidx) >= 32'(MAX_PARTS);

    assign out_free = !r_out_valid || i_ready;
    assign pos_ok   = r_s1_valid && (r_act == ACT_POS) && r_finished && !eidx_bad;
    assign s1_emit  = r_s1_valid && !pos_ok && out_free;
    assign s1_stay  = !(r_act inside {ACT_CLEAR, ACT_FINISH, ACT_POS});
    assign in_rdy   = (r_state == S_RUN) && (!r_s1_valid || (s1_emit && s1_stay));
    assign accept   = i_valid && in_rdy;
    assign walk_last = r_walk_dv && (r_walk_wa == LAST_PART);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_walk_idx == SWEEP_END) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (pos_ok) begin
                    n_state = S_POS;
                end else if (s1_emit && r_act == ACT_CLEAR) begin
                    n_state = S_CLEAR;
                end else if (s1_emit && r_act == ACT_FINISH) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_last) begin
                    n_state = S_RUN;
                end
            end
            S_POS: begin
                if (out_free) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // result of the beat in the pipe stage
    always_comb begin
        s1_value  = '0;
        s1_status = STS_OK;
        case (r_act)
            ACT_LOAD: begin
                if (lbl_bad) begin
                    s1_status = STS_BAD_LABEL;
                end else if (store_full) begin
                    s1_status = STS_FULL;
                end else begin
                    s1_value = VALUE_W'(cur_cnt);
                end
            end
            ACT_FINISH: begin
                s1_value = VALUE_W'(r_ec);
            end
            ACT_POS: begin
                if (!r_finished) begin
                    s1_status = STS_NOT_FINISHED;
                end else if (eidx_bad) begin
                    s1_status = STS_BAD_INDEX;
                end
            end
            ACT_START: begin
                if (!r_finished) begin
                    s1_status = STS_NOT_FINISHED;
                end else if (pidx_bad) begin
                    s1_status = STS_BAD_INDEX;
                end else if (pidx_top) begin
                    s1_value = VALUE_W'(r_ec);
                end else begin
                    s1_value = VALUE_W'(cur_start);
                end
            end
            default: ;
        endcase
    end

    // memory control and register updates
    always_comb begin
        o_bkt_we     = 1'b0;
        o_bkt_waddr  = '0;
        o_bkt_wdata  = '0;
        o_bkt_raddr  = '0;
        o_elem_we    = 1'b0;
        o_elem_waddr = r_ec[IDX_W-1:0];
        o_elem_wdata = {PART_W'(r_label), IDX_W'(cur_cnt)};
        o_elem_raddr = in_rdy ? IDX_W'(i_element_index) : IDX_W'(r_eidx);
        n_s1_valid   = 1'b0;
        n_ec         = r_ec;
        n_finished   = r_finished;
        n_walk_idx   = r_walk_idx;
        n_walk_dv    = 1'b0;
        n_walk_wa    = r_walk_wa;
        n_run        = r_run;
        n_pos_addr   = r_pos_addr;
        n_pos_rank   = r_pos_rank;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        case (r_state)
            S_CLEAR: begin
                o_bkt_we    = 1'b1;
                o_bkt_waddr = r_walk_idx[PART_W-1:0];
                n_walk_idx  = r_walk_idx + 1'b1;
            end
            S_RUN: begin
                if (r_s1_valid && r_act == ACT_POS) begin
                    o_bkt_raddr = elem_lbl;
                end else if (in_rdy) begin
                    o_bkt_raddr = (i_action == ACT_LOAD) ? PART_W'(i_label)
                                                         : PART_W'(i_part_index);
                end else begin
                    // stalled beat re-reads its own bucket
                    o_bkt_raddr = (r_act == ACT_LOAD) ? PART_W'(r_label)
                                                      : PART_W'(r_pidx);
                end

                if (in_rdy) begin
                    n_s1_valid = accept;
                end else begin
                    n_s1_valid = r_s1_valid && !s1_emit && !pos_ok;
                end

                if (pos_ok) begin
                    n_pos_addr = elem_lbl;
                    n_pos_rank = elem_rank;
                end

                if (s1_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = s1_value;
                    n_out_status = s1_status;
                    case (r_act)
                        ACT_CLEAR: begin
                            n_ec       = '0;
                            n_finished = 1'b0;
                            n_walk_idx = '0;
                        end
                        ACT_LOAD: begin
                            if (!lbl_bad && !store_full) begin
                                o_bkt_we    = 1'b1;
                                o_bkt_waddr = PART_W'(r_label);
                                o_bkt_wdata = {cur_cnt + 1'b1, cur_start};
                                o_elem_we   = 1'b1;
                                n_ec        = r_ec + 1'b1;
                                n_finished  = 1'b0;
                            end
                        end
                        ACT_FINISH: begin
                            n_walk_idx = '0;
                            n_run      = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                // read bucket i while bucket i-1 gets its start written back
                if (r_walk_idx != WALK_END) begin
                    o_bkt_raddr = r_walk_idx[PART_W-1:0];
                    n_walk_idx  = r_walk_idx + 1'b1;
                    n_walk_dv   = 1'b1;
                    n_walk_wa   = r_walk_idx[PART_W-1:0];
                end
                if (r_walk_dv) begin
                    o_bkt_we    = 1'b1;
                    o_bkt_waddr = r_walk_wa;
                    o_bkt_wdata = {rd_cnt, r_run};
                    n_run       = r_run + rd_cnt;
                end
                if (walk_last) begin
                    n_finished = 1'b1;
                end
            end
            S_POS: begin
                o_bkt_raddr = r_pos_addr;
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = VALUE_W'(CNT_W'(r_pos_rank) + rd_start);
                    n_out_status = STS_OK;
                end
            end
            default: ;
        endcase

        n_fwd = o_bkt_we && (o_bkt_waddr == o_bkt_raddr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_s1_valid  <= 1'b0;
            r_ec        <= '0;
            r_finished  <= 1'b0;
            r_fwd       <= 1'b0;
            r_walk_idx  <= '0;
            r_walk_dv   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_s1_valid  <= n_s1_valid;
            r_ec        <= n_ec;
            r_finished  <= n_finished;
            r_fwd       <= n_fwd;
            r_walk_idx  <= n_walk_idx;
            r_walk_dv   <= n_walk_dv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act   <= t_action'(i_action);
            r_label <= i_label;
            r_eidx  <= i_element_index;
            r_pidx  <= i_part_index;
        end
        r_fwd_data   <= o_bkt_wdata;
        r_walk_wa    <= n_walk_wa;
        r_run        <= n_run;
        r_pos_addr   <= n_pos_addr;
        r_pos_rank   <= n_pos_rank;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_ready  = in_rdy;
    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

endmodule

// ----- rtl/counting_sort_rank_engine.sv -----
// ============================================================================
// counting_sort_rank_engine
// Stable counting-sort ranking: per-bucket element ranks, prefix-sum bucket
// starts and sorted-position lookup, kept in two synchronous memories.
// ============================================================================
//  channel   direction  handshake              payload
//  request   in         i_valid / o_ready      i_action, i_label,
//                                              i_element_index, i_part_index
//  result    out        o_valid / i_ready      o_value, o_status
//  config    in         i_cfg_we (no wait)     i_cfg_data (parts in use)
//
//  Load, read start, clear result and bad beats: loads go back to back while
//  results are taken, through a forwarded bucket read-modify-write.
//  Read position: element word read, then bucket start read.
//  Finish: prefix-sum walk, one bucket memory word per cycle.
//  Clear and reset: zeroing sweep of the whole bucket memory, o_ready low
//  meanwhile. A held result stalls the pipe stage behind it.
// ============================================================================
module counting_sort_rank_engine
    import csre_pkg::*;
#(
    parameter int MAX_ITEMS = 4096,
    parameter int MAX_PARTS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PARTS_W-1:0]  i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [LABEL_W-1:0]  i_label,
    input  logic [EIDX_W-1:0]   i_element_index,
    input  logic [PIDX_W-1:0]   i_part_index,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [VALUE_W-1:0]  o_value,
    output logic [STATUS_W-1:0] o_status
);

    localparam int IDX_W  = $clog2(MAX_ITEMS);
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int PART_W = $clog2(MAX_PARTS);
    localparam int BKT_W  = 2 * CNT_W;
    localparam int ELEM_W = PART_W + IDX_W;

    logic [PARTS_W-1:0] r_parts_in_use;

    logic              bkt_we;
    logic [PART_W-1:0] bkt_waddr;
    logic [BKT_W-1:0]  bkt_wdata;
    logic [PART_W-1:0] bkt_raddr;
    logic [BKT_W-1:0]  bkt_rdata;
    logic              elem_we;
    logic [IDX_W-1:0]  elem_waddr;
    logic [ELEM_W-1:0] elem_wdata;
    logic [IDX_W-1:0]  elem_raddr;
    logic [ELEM_W-1:0] elem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parts_in_use <= PARTS_W'(1);
        end else if (i_cfg_we) begin
            r_parts_in_use <= i_cfg_data;
        end
    end

    csre_ctrl #(
        .MAX_ITEMS (MAX_ITEMS),
        .MAX_PARTS (MAX_PARTS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_parts         (r_parts_in_use),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_action        (i_action),
        .i_label         (i_label),
        .i_element_index (i_element_index),
        .i_part_index    (i_part_index),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_value         (o_value),
        .o_status        (o_status),
        .o_bkt_we        (bkt_we),
        .o_bkt_waddr     (bkt_waddr),
        .o_bkt_wdata     (bkt_wdata),
        .o_bkt_raddr     (bkt_raddr),
        .i_bkt_rdata     (bkt_rdata),
        .o_elem_we       (elem_we),
        .o_elem_waddr    (elem_waddr),
        .o_elem_wdata    (elem_wdata),
        .o_elem_raddr    (elem_raddr),
        .i_elem_rdata    (elem_rdata)
    );

    // bucket words: {count, start}
    csre_ram #(
        .WIDTH (BKT_W),
        .DEPTH (MAX_PARTS)
    ) u_bkt_ram (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (bkt_wdata),
        .i_raddr (bkt_raddr),
        .o_rdata (bkt_rdata)
    );

    // element words: {label, rank}
    csre_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ITEMS)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (elem_waddr),
        .i_wdata (elem_wdata),
        .i_raddr (elem_raddr),
        .o_rdata (elem_rdata)
    );

endmodule

// ----- rtl/csre_checker.sv -----
// ============================================================================
// csre_checker
// Port-level checks of the rank engine, bound to the top level.
// ============================================================================
module csre_checker
    import csre_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input logic [VALUE_W-1:0]  o_value,
    input logic [STATUS_W-1:0] o_status
);

    logic [2:0] r_pending;

    // requests taken minus results delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 3'(i_valid && o_ready) - 3'(o_valid && i_ready);
        end
    end

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_value) && $stable(o_status)))
        else $error("result beat changed while stalled");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |-> (r_pending != 3'd0))
        else $error("result beat without a request");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd2)
        else $error("more than two requests in flight");

    a_error_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STS_OK) |-> (o_value == '0))
        else $error("error result carries a nonzero value");

    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_ready && !o_valid))
        else $error("ready or valid right after reset");

endmodule

bind counting_sort_rank_engine csre_checker u_csre_checker (.*);
